// ----- rtl/bts_pkg.sv -----
// Shared types, widths and helpers for the bass/treble shelving equaliser.
// No dependencies; every other file in rtl/ imports this package.

package bts_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_BITS = 24;               // Q1.23 samples
    localparam int COEF_BITS   = 20;               // Q4.16 coefficients
    localparam int INT_BITS    = SAMPLE_BITS + 4;  // Q5.23 internal values
    localparam int PEAK_BITS   = SAMPLE_BITS + 3;  // Q4.23 unsigned magnitude
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int HEAD_FRAC   = 23;
    localparam int SCALE_FRAC  = 24;

    // Register widths
    localparam int FF_BITS       = 60;
    localparam int FB_BITS       = 40;
    localparam int HEAD_BITS     = 24;
    localparam int SCALE_BITS    = 32;
    localparam int CFG_DATA_BITS = 60;
    localparam int CFG_IDX_BITS  = 3;

    // Register indexes of the write port; the last index has no register behind it
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE,
        REG_BASS_FF,
        REG_BASS_FB,
        REG_TREBLE_FF,
        REG_TREBLE_FB,
        REG_HEADROOM,
        REG_SCALE,
        REG_SPARE
    } cfg_idx_t;

    // Shared multiplier: gain or coefficient (signed, room for negation) by value
    localparam int OPA_BITS  = (SCALE_BITS + 1 > COEF_BITS + 1) ? SCALE_BITS + 1 : COEF_BITS + 1;
    localparam int OPB_BITS  = INT_BITS;
    localparam int PROD_BITS = OPA_BITS + OPB_BITS;

    // History RAM: four entries per shelf
    localparam int HIST_DEPTH     = 8;
    localparam int HIST_ADDR_BITS = 3;

    // Entry offsets within one shelf
    localparam logic [1:0] OFS_X1 = 2'd0;
    localparam logic [1:0] OFS_X2 = 2'd1;
    localparam logic [1:0] OFS_Y1 = 2'd2;
    localparam logic [1:0] OFS_Y2 = 2'd3;

    // Coefficient slots within a packed register
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clear_history;
        logic                          clear_peak;
        logic                          block_end;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] result_sample;
        logic [PEAK_BITS-1:0]          peak;
        logic                          block_end_out;
    } result_t;

    typedef struct packed {
        logic                    mode;
        logic [FF_BITS-1:0]      bass_feedforward;
        logic [FB_BITS-1:0]      bass_feedback;
        logic [FF_BITS-1:0]      treble_feedforward;
        logic [FB_BITS-1:0]      treble_feedback;
        logic [HEAD_BITS-1:0]    inverse_headroom;
        logic [SCALE_BITS-1:0]   output_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        WR_HIST,
        WR_X,
        WR_Y
    } wr_sel_t;

    typedef enum logic [2:0] {
        OPA_B0,
        OPA_B1,
        OPA_B2,
        OPA_NEG_A1,
        OPA_NEG_A2,
        OPA_GAIN
    } opa_sel_t;

    typedef enum logic {
        OPB_HIST,
        OPB_X
    } opb_sel_t;

    // Sequencer to datapath
    typedef struct packed {
        logic                      accept;
        logic                      treble;
        logic [HIST_ADDR_BITS-1:0] rd_addr;
        logic                      wr_en;
        logic [HIST_ADDR_BITS-1:0] wr_addr;
        wr_sel_t                   wr_sel;
        logic                      mul_en;
        opa_sel_t                  opa_sel;
        opb_sel_t                  opb_sel;
        logic                      acc_clr;
        logic                      load_y;
        logic                      hist_set;
        logic                      load_result;
    } ctl_t;

    // Pick one coefficient out of a packed register; bits beyond the word read as zero
    function automatic logic signed [COEF_BITS-1:0] coef_field(
        input logic [FF_BITS-1:0] word,
        input logic [1:0]         idx
    );
        logic [FF_BITS+3*COEF_BITS-1:0] wide;
        wide = {{(3*COEF_BITS){1'b0}}, word};
        return wide[idx*COEF_BITS +: COEF_BITS];
    endfunction

endpackage

// ----- rtl/bass_treble_shelf_biquad.sv -----
// Top level of the bass/treble shelving equaliser: configuration registers and
// the sequencer and datapath. Depends on bts_pkg, bts_ctrl and bts_datapath.

// A sample transferred on the item channel comes out on the result channel as
// one result. In filter mode (mode 0) it runs through a low-shelf then a
// high-shelf direct form I biquad, the running peak of the filter output is
// updated and the output is scaled by inverse_headroom; in scale mode (mode 1)
// the sample is only multiplied by output_scale. All products go through one
// shared multiplier with a registered accumulator, and the eight filter
// history values live in a small RAM with a registered read, so the rate
// is set by that multiplier and the RAM's single read port; the block takes
// no new item until the last one's result has gone into the output register.
// The result sits in that output register, so the next item is taken while
// a result still waits; the block stalls only when a new result is due and
// the old one is not yet taken. The history RAM needs no clearing pass:
// after reset or a clear_history flag it reads as zero until the next
// filter-mode item rewrites every entry. Configuration is written through
// cfg_write/cfg_index/cfg_data, one register per cycle. The user must write
// only while no item is in flight; the block itself does not enforce this.

module bass_treble_shelf_biquad (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  bts_pkg::item_t                       item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output bts_pkg::result_t                     result,
    input  logic                                 cfg_write,
    input  logic [bts_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import bts_pkg::*;

    // Reset values: unity b0, no feedback, unity gains
    localparam logic [FF_BITS-1:0]    FF_RESET    = FF_BITS'(65536);
    localparam logic [HEAD_BITS-1:0]  HEAD_RESET  = HEAD_BITS'(8388608);
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(16777216);

    cfg_t cfg_reg;
    ctl_t ctl;

    // Register writes; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode               <= 1'b0;
            cfg_reg.bass_feedforward   <= FF_RESET;
            cfg_reg.bass_feedback      <= '0;
            cfg_reg.treble_feedforward <= FF_RESET;
            cfg_reg.treble_feedback    <= '0;
            cfg_reg.inverse_headroom   <= HEAD_RESET;
            cfg_reg.output_scale       <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:      cfg_reg.mode               <= cfg_data[0];
                REG_BASS_FF:   cfg_reg.bass_feedforward   <= cfg_data[FF_BITS-1:0];
                REG_BASS_FB:   cfg_reg.bass_feedback      <= cfg_data[FB_BITS-1:0];
                REG_TREBLE_FF: cfg_reg.treble_feedforward <= cfg_data[FF_BITS-1:0];
                REG_TREBLE_FB: cfg_reg.treble_feedback    <= cfg_data[FB_BITS-1:0];
                REG_HEADROOM:  cfg_reg.inverse_headroom   <= cfg_data[HEAD_BITS-1:0];
                REG_SCALE:     cfg_reg.output_scale       <= cfg_data[SCALE_BITS-1:0];
                default:       cfg_reg.mode               <= cfg_reg.mode;
            endcase
        end
    end

    // Sequencer: schedule, RAM addressing and both handshakes
    bts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .mode         (cfg_reg.mode),
        .ctl          (ctl)
    );

    // History RAM, shared multiplier, rounding, peak and result register
    bts_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .item   (item),
        .result (result)
    );

endmodule

// ----- rtl/bts_ctrl.sv -----
// Sequencer for the shelving equaliser: walks the multiply-accumulate schedule,
// drives the history RAM addresses and owns both handshakes. Depends on bts_pkg.

module bts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    output logic          result_valid,
    input  logic          result_ready,
    input  logic          mode,
    output bts_pkg::ctl_t ctl
);
    import bts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_X1,
        S_Y2,
        S_Y1,
        S_LAST,
        S_B0,
        S_DRAIN,
        S_OUT,
        S_GAIN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   treble_reg, treble_next;
    logic   result_valid_reg, result_valid_next;
    logic   base;

    assign base         = treble_reg;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        ctl               = '0;
        ctl.treble        = treble_reg;
        ctl.rd_addr       = {1'b0, OFS_X2};
        ctl.wr_addr       = {base, OFS_X1};
        ctl.wr_sel        = WR_HIST;
        ctl.opa_sel       = OPA_B0;
        ctl.opb_sel       = OPB_HIST;
        state_next        = state_reg;
        treble_next       = treble_reg;
        result_valid_next = result_valid_reg && !result_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                // bass x2 is read ahead so that the first product can start at once
                ctl.accept  = item_valid;
                ctl.acc_clr = item_valid;
                if (item_valid)
                begin
                    treble_next = 1'b0;
                    state_next  = mode ? S_GAIN : S_X1;
                end
            end
            S_X1:
            begin
                ctl.rd_addr = {base, OFS_X1};
                ctl.mul_en  = 1'b1;
                ctl.opa_sel = OPA_B2;
                state_next  = S_Y2;
            end
            S_Y2:
            begin
                ctl.rd_addr = {base, OFS_Y2};
                ctl.mul_en  = 1'b1;
                ctl.opa_sel = OPA_B1;
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = {base, OFS_X2};
                state_next  = S_Y1;
            end
            S_Y1:
            begin
                ctl.rd_addr = {base, OFS_Y1};
                ctl.mul_en  = 1'b1;
                ctl.opa_sel = OPA_NEG_A2;
                state_next  = S_LAST;
            end
            S_LAST:
            begin
                ctl.mul_en  = 1'b1;
                ctl.opa_sel = OPA_NEG_A1;
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = {base, OFS_Y2};
                state_next  = S_B0;
            end
            S_B0:
            begin
                ctl.mul_en  = 1'b1;
                ctl.opa_sel = OPA_B0;
                ctl.opb_sel = OPB_X;
                ctl.wr_en   = 1'b1;
                ctl.wr_sel  = WR_X;
                ctl.wr_addr = {base, OFS_X1};
                state_next  = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // treble x2 is read ahead here, no clash with the bass write
                ctl.rd_addr = {1'b1, OFS_X2};
                ctl.wr_en   = 1'b1;
                ctl.wr_sel  = WR_Y;
                ctl.wr_addr = {base, OFS_Y1};
                ctl.load_y  = 1'b1;
                ctl.acc_clr = 1'b1;
                if (treble_reg)
                begin
                    ctl.hist_set = 1'b1;
                    state_next   = S_GAIN;
                end
                else
                begin
                    treble_next = 1'b1;
                    state_next  = S_X1;
                end
            end
            S_GAIN:
            begin
                ctl.mul_en  = 1'b1;
                ctl.opa_sel = OPA_GAIN;
                ctl.opb_sel = OPB_X;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    ctl.load_result   = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            treble_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            treble_reg       <= treble_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // The schedule never reads and writes the same history entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (ctl.wr_addr != ctl.rd_addr))
        else $error("history RAM read and write hit the same entry");

    // A finished result never overwrites one still waiting in the output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_result |-> (!result_valid_reg || result_ready))
        else $error("result register overwritten before transfer");

endmodule

// ----- rtl/bts_datapath.sv -----
// Datapath for the shelving equaliser: history RAM, shared multiplier and
// accumulator, rounding and saturation, peak tracker and result register. Depends on bts_pkg.

module bts_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  bts_pkg::ctl_t    ctl,
    input  bts_pkg::cfg_t    cfg,
    input  bts_pkg::item_t   item,
    output bts_pkg::result_t result
);
    import bts_pkg::*;

    localparam logic signed [PROD_BITS-1:0] Y_HALF = PROD_BITS'(1) << (COEF_FRAC - 1);
    localparam logic signed [PROD_BITS-1:0] H_HALF = PROD_BITS'(1) << (HEAD_FRAC - 1);
    localparam logic signed [PROD_BITS-1:0] S_HALF = PROD_BITS'(1) << (SCALE_FRAC - 1);
    localparam logic signed [PROD_BITS-1:0] Y_MAX  = (PROD_BITS'(1) << (INT_BITS - 1)) - 1;
    localparam logic signed [PROD_BITS-1:0] Y_MIN  = -Y_MAX - 1;
    localparam logic signed [PROD_BITS-1:0] R_MAX  = (PROD_BITS'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [PROD_BITS-1:0] R_MIN  = -R_MAX - 1;

    logic [INT_BITS-1:0]           hist_mem [HIST_DEPTH];
    logic signed [INT_BITS-1:0]    rd_q_reg;
    logic                          hist_valid_reg;
    logic signed [INT_BITS-1:0]    hist_val;

    logic signed [INT_BITS-1:0]    x_cur_reg;
    logic                          block_end_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic                          prod_vld_reg;
    logic signed [PROD_BITS-1:0]   acc_reg;
    logic [PEAK_BITS-1:0]          peak_reg, peak_next;
    result_t                       result_reg;

    logic [FF_BITS-1:0]            ff_word, fb_word;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [OPA_BITS-1:0]    coef_ext;
    logic signed [OPA_BITS-1:0]    opa;
    logic signed [OPB_BITS-1:0]    opb;
    logic signed [INT_BITS-1:0]    wr_data;

    logic signed [PROD_BITS-1:0]   y_rnd;
    logic signed [INT_BITS-1:0]    y_sat;
    logic signed [PROD_BITS-1:0]   r_rnd;
    logic signed [SAMPLE_BITS-1:0] r_sat;
    logic [INT_BITS-1:0]           mag_full;
    logic [PEAK_BITS-1:0]          mag;

    // Entries read as zero until a full filter pass rewrites them after a clear
    assign hist_val = hist_valid_reg ? rd_q_reg : '0;

    // Coefficient and gain operand
    always_comb
    begin
        ff_word = ctl.treble ? cfg.treble_feedforward : cfg.bass_feedforward;
        fb_word = FF_BITS'(ctl.treble ? cfg.treble_feedback : cfg.bass_feedback);
        case (ctl.opa_sel)
            OPA_B0:     coef = coef_field(ff_word, SLOT_0);
            OPA_B1:     coef = coef_field(ff_word, SLOT_1);
            OPA_B2:     coef = coef_field(ff_word, SLOT_2);
            OPA_NEG_A1: coef = coef_field(fb_word, SLOT_0);
            OPA_NEG_A2: coef = coef_field(fb_word, SLOT_1);
            default:    coef = coef_field(ff_word, SLOT_0);
        endcase
        coef_ext = OPA_BITS'(coef);
        case (ctl.opa_sel) inside
            OPA_NEG_A1, OPA_NEG_A2: opa = -coef_ext;
            OPA_GAIN:
            begin
                if (cfg.mode)
                    opa = signed'(OPA_BITS'(cfg.output_scale));
                else
                    opa = signed'(OPA_BITS'(cfg.inverse_headroom));
            end
            default:                opa = coef_ext;
        endcase
        opb = (ctl.opb_sel == OPB_X) ? x_cur_reg : hist_val;
    end

    // Shelf output: round half up, saturate to the internal range
    always_comb
    begin
        y_rnd = (acc_reg + Y_HALF) >>> COEF_FRAC;
        if (y_rnd > Y_MAX)
            y_sat = Y_MAX[INT_BITS-1:0];
        else if (y_rnd < Y_MIN)
            y_sat = Y_MIN[INT_BITS-1:0];
        else
            y_sat = y_rnd[INT_BITS-1:0];

        case (ctl.wr_sel)
            WR_X:    wr_data = x_cur_reg;
            WR_Y:    wr_data = y_sat;
            default: wr_data = hist_val;
        endcase
    end

    // Final gain: round half up, saturate to the sample range
    always_comb
    begin
        if (cfg.mode)
            r_rnd = (prod_reg + S_HALF) >>> SCALE_FRAC;
        else
            r_rnd = (prod_reg + H_HALF) >>> HEAD_FRAC;
        if (r_rnd > R_MAX)
            r_sat = R_MAX[SAMPLE_BITS-1:0];
        else if (r_rnd < R_MIN)
            r_sat = R_MIN[SAMPLE_BITS-1:0];
        else
            r_sat = r_rnd[SAMPLE_BITS-1:0];
    end

    // Peak magnitude; the most negative output clamps to the largest positive value
    always_comb
    begin
        mag_full = x_cur_reg[INT_BITS-1] ? (~x_cur_reg + 1'b1) : x_cur_reg;
        mag      = mag_full[INT_BITS-1] ? '1 : mag_full[PEAK_BITS-1:0];
        peak_next = peak_reg;
        if (ctl.accept && item.clear_peak)
            peak_next = '0;
        else if (ctl.load_result && !cfg.mode && (mag > peak_reg))
            peak_next = mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= 1'b0;
            prod_vld_reg   <= 1'b0;
            peak_reg       <= '0;
        end
        else
        begin
            if (ctl.accept && item.clear_history)
                hist_valid_reg <= 1'b0;
            else if (ctl.hist_set)
                hist_valid_reg <= 1'b1;
            prod_vld_reg <= ctl.mul_en;
            peak_reg     <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            hist_mem[ctl.wr_addr] <= wr_data;
        rd_q_reg <= hist_mem[ctl.rd_addr];

        if (ctl.mul_en)
            prod_reg <= opa * opb;

        if (ctl.acc_clr)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + prod_reg;

        // Hold the block end mark aside; a result may still wait in the output register
        if (ctl.accept)
        begin
            x_cur_reg     <= INT_BITS'(item.sample);
            block_end_reg <= item.block_end;
        end
        else if (ctl.load_y)
            x_cur_reg <= y_sat;

        if (ctl.load_result)
        begin
            result_reg.result_sample <= r_sat;
            result_reg.peak          <= peak_next;
            result_reg.block_end_out <= block_end_reg;
        end
    end

    assign result = result_reg;

    // The accumulator is only cleared once every product has landed in it
    a_no_lost_product: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.acc_clr |-> !prod_vld_reg)
        else $error("accumulator cleared with a product pending");

    // Peak only grows, unless an item asked for it to be cleared
    a_peak_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && item.clear_peak) || (peak_next >= peak_reg))
        else $error("peak level fell without a clear");

endmodule
